[rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_SEARCH = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int DataWidth = 32;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;     // shift towards the tail, write value at pos
    logic del;     // shift towards the head from pos onwards
    logic load;    // capture local match into the collect registers
    logic prop;    // one step of the collect chain
    logic search;
    logic read;
  } cell_ctrl_t;

endpackage

[rtl/ple_req_if.sv]
// ----------------------------------------------------------------------------
// ple_req_if
// Request channel: mode, position and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ple_req_if #(
  parameter int PW = 7
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [PW-1:0]                 position;
  logic signed [ple_pkg::DataWidth-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

[rtl/ple_rsp_if.sv]
// ----------------------------------------------------------------------------
// ple_rsp_if
// Response channel: read data, found flag, status and list length.
// ----------------------------------------------------------------------------
interface ple_rsp_if #(
  parameter int PW = 7
);
  logic                          valid;
  logic                          ready;
  logic signed [ple_pkg::DataWidth-1:0] read_value;
  logic                          found;
  logic [1:0]                    status;
  logic [PW-1:0]                 list_length;

  modport source (output valid, output read_value, output found, output status,
                  output list_length, input ready);
  modport sink   (input valid, input read_value, input found, input status,
                  input list_length, output ready);
endinterface

[rtl/positional_list_engine_core.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed 32-bit entries held in a chain of cells.
// ----------------------------------------------------------------------------
// Insert and delete: the request is registered and executed in ST_EXEC, where
//   the whole chain shifts at once; the response is sent from ST_DONE.
// Read and search: after ST_EXEC loads the match, the result walks the cell
//   chain in ST_SCAN one cell per cycle to the tail, then ST_COLLECT and ST_DONE.
// One request in flight; a finished response waits in the output register
//   while the next request is taken. rst (synchronous) empties the list.
// ----------------------------------------------------------------------------
module positional_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic    clk,
  input  logic    rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam int DW = ple_pkg::DataWidth;
  localparam logic [PW-1:0] Cap     = PW'(CAPACITY);
  localparam logic [SW-1:0] ScanEnd = SW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_COLLECT,
    ST_DONE
  } state_t;

  state_t            state;
  logic [PW-1:0]     count;
  logic [SW-1:0]     scan_cnt;
  ple_pkg::mode_t    q_mode;
  logic [PW-1:0]     q_pos;
  logic [DW-1:0]     q_value;

  logic [DW-1:0]     res_rd;
  logic              res_found;
  logic [1:0]        res_status;
  logic [PW-1:0]     res_len;

  logic              rsp_valid;
  logic [DW-1:0]     rsp_rd;
  logic              rsp_found;
  logic [1:0]        rsp_status;
  logic [PW-1:0]     rsp_len;

  ple_pkg::cell_ctrl_t ctrl;

  logic [DW-1:0] cell_data [CAPACITY];
  logic          cell_hit  [CAPACITY];
  logic [DW-1:0] cell_rd   [CAPACITY];

  logic ins_ok, del_ok, read_ok;

  assign ins_ok  = (q_pos <= count) && (count != Cap);
  assign del_ok  = (q_pos < count);
  assign read_ok = (q_pos < count);

  always_comb begin
    ctrl = '0;
    if (state == ST_EXEC) begin
      unique case (q_mode)
        ple_pkg::MODE_INSERT: ctrl.ins  = ins_ok;
        ple_pkg::MODE_DELETE: ctrl.del  = del_ok;
        ple_pkg::MODE_READ: begin
          ctrl.load = read_ok;
          ctrl.read = 1'b1;
        end
        ple_pkg::MODE_SEARCH: begin
          ctrl.load   = 1'b1;
          ctrl.search = 1'b1;
        end
        default: ctrl = '0;
      endcase
    end else if (state == ST_SCAN) begin
      ctrl.prop = 1'b1;
    end
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DW-1:0] l_data, r_data, l_rd;
      logic          l_hit;
      if (i == 0) begin : g_head
        assign l_data = q_value;
        assign l_hit  = 1'b0;
        assign l_rd   = '0;
      end else begin : g_body
        assign l_data = cell_data[i-1];
        assign l_hit  = cell_hit[i-1];
        assign l_rd   = cell_rd[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign r_data = cell_data[i];
      end else begin : g_inner
        assign r_data = cell_data[i+1];
      end

      ple_cell #(
        .IDX (i),
        .PW  (PW)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .pos        (q_pos),
        .cnt        (count),
        .value      (q_value),
        .left_data  (l_data),
        .right_data (r_data),
        .left_hit   (l_hit),
        .left_rd    (l_rd),
        .data       (cell_data[i]),
        .hit        (cell_hit[i]),
        .rd         (cell_rd[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // in ST_DONE the output register is reloaded instead
      if (rsp_valid && rsp.ready && (state != ST_DONE)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            q_mode  <= ple_pkg::mode_t'(req.mode);
            q_pos   <= req.position;
            q_value <= req.value;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_rd     <= '0;
          res_found  <= 1'b0;
          res_status <= ple_pkg::STATUS_OK;
          res_len    <= count;
          state      <= ST_DONE;
          unique case (q_mode)
            ple_pkg::MODE_INSERT: begin
              if (q_pos > count) begin
                res_status <= ple_pkg::STATUS_RANGE;
              end else if (count == Cap) begin
                res_status <= ple_pkg::STATUS_FULL;
              end else begin
                count   <= count + PW'(1);
                res_len <= count + PW'(1);
              end
            end
            ple_pkg::MODE_DELETE: begin
              if (del_ok) begin
                count   <= count - PW'(1);
                res_len <= count - PW'(1);
              end else begin
                res_status <= ple_pkg::STATUS_RANGE;
              end
            end
            ple_pkg::MODE_READ: begin
              if (read_ok) begin
                scan_cnt <= SW'(1);
                state    <= ST_SCAN;
              end else begin
                res_status <= ple_pkg::STATUS_RANGE;
              end
            end
            ple_pkg::MODE_SEARCH: begin
              scan_cnt <= SW'(1);
              state    <= ST_SCAN;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_SCAN: begin
          if (scan_cnt == ScanEnd) begin
            state <= ST_COLLECT;
          end else begin
            scan_cnt <= scan_cnt + SW'(1);
          end
        end
        ST_COLLECT: begin
          // tail cell now holds the OR over the whole chain
          res_rd    <= cell_rd[CAPACITY-1];
          res_found <= cell_hit[CAPACITY-1];
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_rd     <= res_rd;
            rsp_found  <= res_found;
            rsp_status <= res_status;
            rsp_len    <= res_len;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.read_value  = rsp_rd;
  assign rsp.found       = rsp_found;
  assign rsp.status      = rsp_status;
  assign rsp.list_length = rsp_len;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Cap)
    else $error("list length above capacity");

  a_count_stable_lookup: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && ((q_mode == ple_pkg::MODE_READ) || (q_mode == ple_pkg::MODE_SEARCH))
    |=> $stable(count))
    else $error("read or search changed the list length");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) && (q_mode == ple_pkg::MODE_INSERT) && ins_ok
    |=> (count == $past(count) + PW'(1)))
    else $error("accepted insert did not grow the list");

  a_found_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> (rsp_status == ple_pkg::STATUS_OK))
    else $error("found flag with error status");

  a_shift_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.del) && !(ctrl.load && ctrl.prop))
    else $error("conflicting cell controls");
`endif

endmodule

[rtl/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbours and carries the
// read/search collect chain one step towards the tail.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic                          clk,
  input  ple_pkg::cell_ctrl_t           ctrl,
  input  logic [PW-1:0]                 pos,
  input  logic [PW-1:0]                 cnt,
  input  logic [ple_pkg::DataWidth-1:0] value,
  input  logic [ple_pkg::DataWidth-1:0] left_data,
  input  logic [ple_pkg::DataWidth-1:0] right_data,
  input  logic                          left_hit,
  input  logic [ple_pkg::DataWidth-1:0] left_rd,
  output logic [ple_pkg::DataWidth-1:0] data,
  output logic                          hit,
  output logic [ple_pkg::DataWidth-1:0] rd
);

  localparam logic [PW-1:0] Index = PW'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (Index == pos) begin
        data <= value;
      end else if (Index > pos) begin
        data <= left_data;
      end
    end else if (ctrl.del) begin
      if (Index >= pos) begin
        data <= right_data;
      end
    end

    // at most one cell matches a read, so OR-ing the chain is a mux
    if (ctrl.load) begin
      hit <= ctrl.search && (Index < cnt) && (data == value);
      rd  <= (ctrl.read && (Index == pos)) ? data : '0;
    end else if (ctrl.prop) begin
      hit <= hit | left_hit;
      rd  <= rd | left_rd;
    end
  end

endmodule

[tb/sv/ple_list_checker.sv]
// ----------------------------------------------------------------------------
// ple_list_checker
// Watches the request and response channels of the list engine, keeps its own
// copy of the list, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module ple_list_checker #(
  parameter int CAPACITY = 64,
  parameter int PW       = 7
) (
  input  logic clk,
  input  logic rst,
  ple_req_if   req,
  ple_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  typedef struct packed {
    logic signed [DataWidth-1:0] read_value;
    logic                        found;
    logic [1:0]                  status;
    logic [PW-1:0]               list_length;
  } list_rsp_t;

  logic signed [DataWidth-1:0] cells [CAPACITY];
  int                          list_len;
  list_rsp_t                   expected_rsps [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
  end

  // Applies one request to the local list and returns the response it owes.
  function automatic list_rsp_t apply_request(mode_t m, logic [PW-1:0] p,
                                              logic signed [DataWidth-1:0] v);
    list_rsp_t r;
    int        i;
    r = '0;
    case (m)
      MODE_INSERT: begin
        if (p > list_len) begin
          r.status = STATUS_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          for (i = list_len; i > p; i--) cells[i] = cells[i-1];
          cells[p] = v;
          list_len++;
        end
      end
      MODE_DELETE: begin
        if (list_len == 0 || p >= list_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) cells[i] = cells[i+1];
          list_len--;
        end
      end
      MODE_READ: begin
        if (p >= list_len) r.status = STATUS_RANGE;
        else r.read_value = cells[p];
      end
      default: begin
        // only live entries take part in the search
        for (i = 0; i < list_len; i++) begin
          if (cells[i] == v) r.found = 1'b1;
        end
      end
    endcase
    r.list_length = list_len[PW-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    list_rsp_t want;
    if (rst) begin
      list_len = 0;
      expected_rsps.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected response, expected none, actual status %0d length %0d",
                   $time, rsp.status, rsp.list_length);
        end else begin
          want = expected_rsps.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("found", 32'(want.found), 32'(rsp.found));
          check_field("status", 32'(want.status), 32'(rsp.status));
          check_field("list_length", 32'(want.list_length), 32'(rsp.list_length));
        end
      end
      if (req.valid && req.ready) begin
        expected_rsps.push_back(apply_request(mode_t'(req.mode), req.position, req.value));
      end
    end
    pending = expected_rsps.size();
  end

endmodule

[tb/sv/tb_positional_list_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_positional_list_engine_core
// Drives directed and random list requests into the engine with bursty
// traffic and a stalling receiver; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int PW           = 7;
  localparam int NUM_RANDOM   = 1000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIX
  } traffic_phase_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  logic hold_off_go;
  int   burst_left;
  int   list_len;
  logic signed [DataWidth-1:0] seen_vals [$];
  traffic_phase_t phase;

  ple_req_if #(.PW(PW)) req_ch ();
  ple_rsp_if #(.PW(PW)) rsp_ch ();

  positional_list_engine_core #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ple_list_checker #(.CAPACITY(CAPACITY), .PW(PW)) u_list_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8ms;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: changes pattern at random intervals, plus one long hold-off.
  initial begin : receiver
    int pattern;
    int left;
    int hold;
    int cyc;
    logic hold_done;
    pattern   = 0;
    left      = 0;
    hold      = 0;
    cyc       = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_off_go && !hold_done) begin
        hold      = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (left == 0) begin
        pattern = $urandom_range(0, 3);
        left    = $urandom_range(20, 80);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        case (pattern)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  // Offers one transaction; bursts of random length separated by random gaps.
  task automatic send_request(input mode_t m, input logic [PW-1:0] p,
                              input logic signed [DataWidth-1:0] v);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
    end
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= m;
    req_ch.position <= p;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) req_ch.valid <= 1'b0;
    case (m)
      MODE_INSERT: begin
        if (p <= list_len && list_len < CAPACITY) begin
          list_len++;
          seen_vals.push_back(v);
          if (seen_vals.size() > 32) void'(seen_vals.pop_front());
        end
      end
      MODE_DELETE: if (p < list_len) list_len--;
      default: ;
    endcase
  endtask

  // Stops offering until every outstanding response has been taken.
  task automatic wait_for_drain();
    if (burst_left > 0) req_ch.valid <= 1'b0;
    burst_left = 0;
    wait (pending == 0);
  endtask

  task automatic send_random();
    int    r;
    mode_t m;
    logic [PW-1:0] p;
    logic signed [DataWidth-1:0] v;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  m = (r < 60) ? MODE_INSERT : (r < 70) ? MODE_DELETE :
                    (r < 85) ? MODE_READ : MODE_SEARCH;
      PH_DRAIN: m = (r < 10) ? MODE_INSERT : (r < 65) ? MODE_DELETE :
                    (r < 82) ? MODE_READ : MODE_SEARCH;
      default:  m = mode_t'(r % 4);
    endcase

    r = $urandom_range(0, 99);
    if (r < 80) begin
      if (m == MODE_INSERT) p = PW'($urandom_range(0, list_len));
      else p = (list_len > 0) ? PW'($urandom_range(0, list_len - 1)) : '0;
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0:       p = '0;
        1:       p = PW'(list_len);
        2:       p = (list_len > 0) ? PW'(list_len - 1) : '0;
        default: p = PW'(CAPACITY);
      endcase
    end else begin
      p = PW'($urandom_range(0, 127));
    end

    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7FFF_FFFF;
        2:       v = '0;
        default: v = -32'sd1;
      endcase
    end else if ((m == MODE_SEARCH && r < 60 || r < 25) && seen_vals.size() > 0) begin
      v = seen_vals[$urandom_range(0, seen_vals.size() - 1)];
    end else begin
      v = $urandom;
    end

    send_request(m, p, v);

    case (phase)
      PH_FILL:  if (list_len == CAPACITY && $urandom_range(0, 7) == 0) phase = PH_DRAIN;
      PH_DRAIN: if (list_len == 0 && $urandom_range(0, 3) == 0) phase = PH_MIX;
      default:  if ($urandom_range(0, 149) == 0) phase = PH_FILL;
    endcase
  endtask

  initial begin : stimulus
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    hold_off_go     = 1'b0;
    burst_left      = 0;
    list_len        = 0;
    phase           = PH_FILL;
    rst             = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list corner cases
    send_request(MODE_READ,   7'd0,   32'sd0);
    send_request(MODE_DELETE, 7'd0,   32'sd0);
    send_request(MODE_SEARCH, 7'd0,   32'sd0);
    send_request(MODE_INSERT, 7'd1,   32'sd5);
    // build a short list with extreme values, inserting at head, tail and middle
    send_request(MODE_INSERT, 7'd0,   32'sh7FFF_FFFF);
    send_request(MODE_INSERT, 7'd0,   32'sh8000_0000);
    send_request(MODE_INSERT, 7'd2,   32'sd0);
    send_request(MODE_INSERT, 7'd1,   -32'sd1);
    send_request(MODE_READ,   7'd0,   32'sd0);
    send_request(MODE_READ,   7'd1,   32'sd0);
    send_request(MODE_READ,   7'd2,   32'sd0);
    send_request(MODE_READ,   7'd3,   32'sd0);
    send_request(MODE_SEARCH, 7'd127, 32'sh8000_0000);
    send_request(MODE_SEARCH, 7'd0,   32'sd12345);
    // out of range positions
    send_request(MODE_READ,   7'd4,   32'sd0);
    send_request(MODE_READ,   7'd127, 32'sd0);
    send_request(MODE_DELETE, 7'd4,   32'sd0);
    send_request(MODE_DELETE, 7'd127, 32'sd0);
    send_request(MODE_INSERT, 7'd127, 32'sd9);
    // delete tail and head, then look again
    send_request(MODE_DELETE, 7'd3,   32'sd0);
    send_request(MODE_DELETE, 7'd0,   32'sd0);
    send_request(MODE_READ,   7'd0,   32'sd0);
    send_request(MODE_SEARCH, 7'd0,   32'sh7FFF_FFFF);
    wait_for_drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == 300) hold_off_go <= 1'b1;
      if (n == 600) wait_for_drain();
      send_random();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
